// File: design/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg: shared types and helpers for the JSON string escaper
// Holds the symbol modes, the controller/datapath link structs and the
// functions that expand one symbol into its output bytes.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam logic [7:0] BSLASH  = 8'h5C;
  localparam logic [7:0] QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_X  = 8'h78;
  localparam logic [7:0] ASCII_0 = 8'h30;

  // How one symbol (a held byte or the new byte) is written out.
  typedef enum logic [1:0] {
    SYM_NONE = 2'd0,
    SYM_RAW  = 2'd1,
    SYM_ESC  = 2'd2,
    SYM_HINT = 2'd3
  } sym_mode_e;

  typedef struct packed {
    logic       accept;
    logic       emit;
    logic       last;
    logic [1:0] idx;
    logic [2:0] pos;
  } jse_cmd_t;

  typedef struct packed {
    logic [1:0] hc;
    logic       new_none;
    logic [2:0] sym_len;
    logic       out_free;
  } jse_sts_t;

  function automatic logic is_escape(input logic [7:0] v);
    logic r;
    case (v)
      8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, QUOTE, BSLASH: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] esc_char(input logic [7:0] v);
    logic [7:0] r;
    case (v)
      8'h08:   r = 8'h62;
      8'h0C:   r = 8'h66;
      8'h0A:   r = 8'h6E;
      8'h0D:   r = 8'h72;
      8'h09:   r = 8'h74;
      default: r = v;
    endcase
    return r;
  endfunction

  // Announced sequence length of a lead byte, zero if it is no lead byte.
  function automatic logic [2:0] lead_len(input logic [7:0] v);
    logic [2:0] r;
    if (v[7:5] == 3'b110) begin
      r = 3'd2;
    end else if (v[7:4] == 4'b1110) begin
      r = 3'd3;
    end else if (v[7:3] == 5'b11110) begin
      r = 3'd4;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // Treatment of a byte seen outside a sequence. SYM_NONE means it opens one.
  function automatic sym_mode_e fresh_kind(input logic [7:0] v);
    sym_mode_e r;
    if (is_escape(v)) begin
      r = SYM_ESC;
    end else if (v == 8'h00) begin
      r = SYM_HINT;
    end else if (!v[7]) begin
      r = SYM_RAW;
    end else if (lead_len(v) != 3'd0) begin
      r = SYM_NONE;
    end else begin
      r = SYM_HINT;
    end
    return r;
  endfunction

  function automatic logic [1:0] num_digits(input logic [7:0] v);
    logic [1:0] r;
    if (v >= 8'd100) begin
      r = 2'd3;
    end else if (v >= 8'd10) begin
      r = 2'd2;
    end else begin
      r = 2'd1;
    end
    return r;
  endfunction

  function automatic logic [2:0] sym_len(input sym_mode_e m, input logic [7:0] v);
    logic [2:0] r;
    case (m)
      SYM_RAW:  r = 3'd1;
      SYM_ESC:  r = 3'd2;
      SYM_HINT: r = 3'd3 + {1'b0, num_digits(v)};
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  // Output byte at position pos of the expansion of one symbol.
  function automatic logic [7:0] sym_byte(input sym_mode_e m, input logic [7:0] v,
                                          input logic [2:0] pos);
    logic [1:0]  hund;
    logic [7:0]  hsub;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tsub;
    logic [3:0]  ones;
    logic [2:0]  j;
    logic [3:0]  dig;
    logic [7:0]  r;
    if (v >= 8'd200) begin
      hund = 2'd2;
      hsub = 8'd200;
    end else if (v >= 8'd100) begin
      hund = 2'd1;
      hsub = 8'd100;
    end else begin
      hund = 2'd0;
      hsub = 8'd0;
    end
    rem  = 7'(v - hsub);
    // rem stays below 100, where multiplying by 205/2048 gives rem / 10 exactly.
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    tsub = 7'(tens) * 7'd10;
    ones = 4'(rem - tsub);
    j    = pos - {1'b0, num_digits(v)};
    case (j)
      3'd0:    dig = {2'b00, hund};
      3'd1:    dig = tens;
      default: dig = ones;
    endcase
    case (m)
      SYM_RAW: begin
        r = v;
      end
      SYM_ESC: begin
        r = (pos == 3'd0) ? BSLASH : esc_char(v);
      end
      SYM_HINT: begin
        if (pos <= 3'd1) begin
          r = BSLASH;
        end else if (pos == 3'd2) begin
          r = CHAR_X;
        end else begin
          r = ASCII_0 + {4'd0, dig};
        end
      end
      default: begin
        r = v;
      end
    endcase
    return r;
  endfunction

endpackage

// File: design/jse_dp.sv
// ----------------------------------------------------------------------------
// jse_dp: escaper datapath
// Keeps the open UTF-8 sequence, plans the symbols of each item and drives
// the output byte register.
// ----------------------------------------------------------------------------
module jse_dp import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  input  logic       in_final_i,
  input  jse_cmd_t   cmd_i,
  output jse_sts_t   sts_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,
  output logic       m_tuser_o,
  output logic       m_tlast_o
);

  // Open sequence, lead byte first.
  logic [7:0] pend_q [3];
  logic [1:0] pc_q, pc_d;
  logic [2:0] sl_q, sl_d;
  logic       pend_we;

  // Plan of the item being written out.
  logic [7:0] ebuf_q [3];
  logic [7:0] nb_q;
  logic       fin_q;
  logic [1:0] hc_q, hc_d;
  sym_mode_e  held_q, held_d;
  sym_mode_e  nk_q, nk_d;

  logic       cont;
  sym_mode_e  fk;
  logic [2:0] ll;

  logic [7:0] sym_v;
  sym_mode_e  sym_m;

  logic       ov_q;
  logic [7:0] od_q;
  logic       ol_q;
  logic       oe_q;

  always_comb begin
    cont    = (in_byte_i[7:6] == 2'b10);
    fk      = fresh_kind(in_byte_i);
    ll      = lead_len(in_byte_i);
    pc_d    = pc_q;
    sl_d    = sl_q;
    pend_we = 1'b0;
    hc_d    = pc_q;
    held_d  = SYM_HINT;
    nk_d    = fk;
    if ((pc_q != 2'd0) && cont) begin
      if (({1'b0, pc_q} + 3'd1) >= sl_q) begin
        // Sequence complete: held bytes and this one pass through.
        held_d = SYM_RAW;
        nk_d   = SYM_RAW;
        pc_d   = 2'd0;
        sl_d   = 3'd0;
      end else if (in_final_i) begin
        nk_d = SYM_HINT;
        pc_d = 2'd0;
        sl_d = 3'd0;
      end else begin
        pend_we = 1'b1;
        hc_d    = 2'd0;
        nk_d    = SYM_NONE;
        pc_d    = pc_q + 2'd1;
      end
    end else begin
      // Held bytes, if any, are a broken sequence; this byte starts afresh.
      pc_d = 2'd0;
      sl_d = 3'd0;
      if (fk == SYM_NONE) begin
        if (in_final_i) begin
          nk_d = SYM_HINT;
        end else begin
          pend_we = 1'b1;
          pc_d    = 2'd1;
          sl_d    = ll;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && pend_we) begin
      if (fk == SYM_NONE && !cont) begin
        pend_q[0] <= in_byte_i;
      end else begin
        pend_q[pc_q] <= in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ebuf_q[0] <= pend_q[0];
      ebuf_q[1] <= pend_q[1];
      ebuf_q[2] <= pend_q[2];
      nb_q      <= in_byte_i;
      fin_q     <= in_final_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= 2'd0;
      sl_q   <= 3'd0;
      hc_q   <= 2'd0;
      held_q <= SYM_NONE;
      nk_q   <= SYM_NONE;
    end else if (cmd_i.accept) begin
      pc_q   <= pc_d;
      sl_q   <= sl_d;
      hc_q   <= hc_d;
      held_q <= held_d;
      nk_q   <= nk_d;
    end
  end

  always_comb begin
    if (cmd_i.idx < hc_q) begin
      sym_v = ebuf_q[cmd_i.idx];
      sym_m = held_q;
    end else begin
      sym_v = nb_q;
      sym_m = nk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (m_tready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      od_q <= sym_byte(sym_m, sym_v, cmd_i.pos);
      ol_q <= cmd_i.last;
      oe_q <= cmd_i.last && fin_q;
    end
  end

  assign sts_o.hc       = hc_q;
  assign sts_o.new_none = (nk_q == SYM_NONE);
  assign sts_o.sym_len  = sym_len(sym_m, sym_v);
  assign sts_o.out_free = !ov_q || m_tready_i;

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = od_q;
  assign m_tuser_o  = ol_q;
  assign m_tlast_o  = oe_q;

endmodule

// File: design/jse_ctrl.sv
// ----------------------------------------------------------------------------
// jse_ctrl: escaper controller
// Takes an item when idle, then walks the planned symbols and the bytes of
// each symbol, one output byte per cycle while the output register is free.
// ----------------------------------------------------------------------------
module jse_ctrl import jse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  jse_sts_t sts_i,
  output jse_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic       state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic [2:0] pos_q, pos_d;
  logic       done;
  logic       sym_end;
  logic       last;

  always_comb begin
    done    = (idx_q == sts_i.hc) && sts_i.new_none;
    sym_end = (pos_q == (sts_i.sym_len - 3'd1));
    last    = sym_end && ((idx_q == sts_i.hc) ||
              (({1'b0, idx_q} + 3'd1 == {1'b0, sts_i.hc}) && sts_i.new_none));
    state_d      = state_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    cmd_o.accept = 1'b0;
    cmd_o.emit   = 1'b0;
    cmd_o.last   = last;
    cmd_o.idx    = idx_q;
    cmd_o.pos    = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = ST_EMIT;
          idx_d   = 2'd0;
          pos_d   = 3'd0;
        end
      end
      ST_EMIT: begin
        if (done) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (last) begin
            state_d = ST_IDLE;
          end else if (sym_end) begin
            idx_d = idx_q + 2'd1;
            pos_d = 3'd0;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_tready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 2'd0;
      pos_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
    end
  end

  // A byte is only written into a free output register.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("byte written into an occupied output register");

  // The walk never passes the new byte's slot.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (idx_q <= sts_i.hc))
    else $error("symbol index beyond the planned symbols");

  // Inside a symbol the byte position stays below its length.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !done) |-> (pos_q < sts_i.sym_len))
    else $error("byte position beyond the symbol length");

  // The last byte of an item brings the controller back to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("controller kept emitting after the last byte of an item");

endmodule

// File: design/json_string_escaper_utf8.sv
// ----------------------------------------------------------------------------
// json_string_escaper_utf8: JSON string escaper with UTF-8 checking
// Escapes a byte stream for use inside a JSON string, one input byte per
// item, and writes out bad UTF-8 bytes as decimal hints.
// ----------------------------------------------------------------------------
// The block takes one text byte per input item (tlast marks the final byte
// of a text) and gives the escaped bytes one per output item. Backspace,
// form feed, newline, carriage return and tab become a backslash and a
// letter; a quote or a backslash gets a leading backslash. ASCII and
// well-formed two- to four-byte UTF-8 sequences pass unchanged, with no
// overlong or surrogate check. A bad byte (a stray continuation byte, a lead
// byte F8 to FF, a NUL byte, or each byte of a broken or truncated sequence)
// is written as two backslashes, 'x' and its decimal value. Bytes of an open
// sequence are held back until it completes, breaks or the text ends. An item
// is taken while the block is idle; its output bytes then go one per cycle
// into the single output byte register while that register is free, up to
// 24 bytes per item, at most 6 per byte held or new. The next item is taken
// as soon as the last byte of the previous one sits in the output register,
// even while the downstream side stalls. On the output, tuser is high on the
// last byte caused by an item and tlast on the last byte of a whole text.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8 import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] in_byte
  input  logic       s_tlast_i,   // in_final
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [7:0] out_byte
  output logic       m_tuser_o,   // [0] out_run_last
  output logic       m_tlast_o    // out_text_end
);

  // Commands from the controller and status back from the datapath.
  jse_cmd_t cmd;
  jse_sts_t sts;

  // The controller owns the input handshake and the symbol walk.
  jse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the open sequence, the plan of the current item and
  // the output register that decouples the two sides.
  jse_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (s_tdata_i),
    .in_final_i (s_tlast_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

// File: tb/jse_escape_checker.sv
// ----------------------------------------------------------------------------
// jse_escape_checker: expected-byte tracker for the JSON string escaper
// Watches both stream channels. It predicts the escaped bytes of every
// accepted input item and compares each output item with the oldest one.
// ----------------------------------------------------------------------------
module jse_escape_checker import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,       // [7:0] in_byte
  input  logic       s_tlast_i,       // in_final
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,       // [7:0] out_byte
  input  logic       m_tuser_i,       // [0] out_run_last
  input  logic       m_tlast_i,       // out_text_end
  output int         fail_count_o,
  output int         open_count_o,
  output int         checked_count_o
);

  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_FF  = 8'h0C;
  localparam logic [7:0] CTRL_LF  = 8'h0A;
  localparam logic [7:0] CTRL_CR  = 8'h0D;
  localparam logic [7:0] CTRL_TAB = 8'h09;
  localparam logic [7:0] CTRL_NUL = 8'h00;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } esc_beat_t;

  esc_beat_t  escaped_q[$];
  logic [7:0] burst_q[$];

  // Open UTF-8 sequence: held bytes, lead byte first, and its announced length.
  logic [7:0] seq_held[3];
  int         held_cnt;
  int         seq_need;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic emit_hint(input logic [7:0] b);
    burst_q.push_back(BSLASH);
    burst_q.push_back(BSLASH);
    burst_q.push_back(CHAR_X);
    if (b >= 8'd100) begin
      burst_q.push_back(ASCII_0 + 8'(b / 8'd100));
    end
    if (b >= 8'd10) begin
      burst_q.push_back(ASCII_0 + 8'((b / 8'd10) % 8'd10));
    end
    burst_q.push_back(ASCII_0 + 8'(b % 8'd10));
  endtask

  task automatic flush_held();
    for (int k = 0; k < held_cnt; k++) begin
      emit_hint(seq_held[k]);
    end
    held_cnt = 0;
    seq_need = 0;
  endtask

  // A byte seen outside any open sequence.
  task automatic escape_fresh(input logic [7:0] b);
    int need;
    need = 0;
    case (b)
      CTRL_BS:  begin burst_q.push_back(BSLASH); burst_q.push_back("b"); end
      CTRL_FF:  begin burst_q.push_back(BSLASH); burst_q.push_back("f"); end
      CTRL_LF:  begin burst_q.push_back(BSLASH); burst_q.push_back("n"); end
      CTRL_CR:  begin burst_q.push_back(BSLASH); burst_q.push_back("r"); end
      CTRL_TAB: begin burst_q.push_back(BSLASH); burst_q.push_back("t"); end
      QUOTE:    begin burst_q.push_back(BSLASH); burst_q.push_back(QUOTE); end
      BSLASH:   begin burst_q.push_back(BSLASH); burst_q.push_back(BSLASH); end
      CTRL_NUL: begin emit_hint(b); end
      default: begin
        if (!b[7]) begin
          burst_q.push_back(b);
        end else begin
          if (b[7:5] == 3'b110) begin
            need = 2;
          end else if (b[7:4] == 4'b1110) begin
            need = 3;
          end else if (b[7:3] == 5'b11110) begin
            need = 4;
          end
          if (need == 0) begin
            emit_hint(b);
          end else begin
            seq_held[0] = b;
            held_cnt    = 1;
            seq_need    = need;
          end
        end
      end
    endcase
  endtask

  // Expected output bytes of one accepted input item, queued in order.
  task automatic predict_escape(input logic [7:0] b, input logic fin);
    esc_beat_t beat;
    burst_q.delete();
    if (held_cnt > 0) begin
      if (b[7:6] == 2'b10) begin
        if (held_cnt + 1 >= seq_need) begin
          for (int k = 0; k < held_cnt; k++) begin
            burst_q.push_back(seq_held[k]);
          end
          burst_q.push_back(b);
          held_cnt = 0;
          seq_need = 0;
        end else begin
          seq_held[held_cnt] = b;
          held_cnt++;
        end
      end else begin
        flush_held();
        escape_fresh(b);
      end
    end else begin
      escape_fresh(b);
    end
    if (fin && held_cnt > 0) begin
      flush_held();
    end
    for (int i = 0; i < burst_q.size(); i++) begin
      beat.data     = burst_q[i];
      beat.run_last = (i == burst_q.size() - 1);
      beat.text_end = (i == burst_q.size() - 1) && fin;
      escaped_q.push_back(beat);
    end
  endtask

  task automatic check_result();
    esc_beat_t want;
    if (escaped_q.size() == 0) begin
      report_mismatch($sformatf("output item %02h with no expected byte waiting", m_tdata_i));
    end else begin
      want = escaped_q.pop_front();
      if (m_tdata_i !== want.data) begin
        report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata_i, want.data));
      end
      if (m_tuser_i !== want.run_last) begin
        report_mismatch($sformatf("out_run_last %b, expected %b on byte %02h",
                                  m_tuser_i, want.run_last, want.data));
      end
      if (m_tlast_i !== want.text_end) begin
        report_mismatch($sformatf("out_text_end %b, expected %b on byte %02h",
                                  m_tlast_i, want.text_end, want.data));
      end
    end
    checked_count_o++;
  endtask

  // Input is handled before output; a result never leaves in the cycle its
  // input item is taken, so the queue order stays right either way.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escaped_q.delete();
      held_cnt        = 0;
      seq_need        = 0;
      fail_count_o    = 0;
      checked_count_o = 0;
      open_count_o    = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        predict_escape(s_tdata_i, s_tlast_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        check_result();
      end
      open_count_o = escaped_q.size();
    end
  end

endmodule

// File: tb/tb_json_string_escaper_utf8.sv
// ----------------------------------------------------------------------------
// tb_json_string_escaper_utf8: regression bench for the JSON string escaper
// Feeds directed and random texts, mostly well-formed UTF-8 with noise and
// broken sequences, under several idle patterns and one long output stall.
// A checker beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb_json_string_escaper_utf8;

  // Half of the 20 unit clock period.
  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 11;
  // Cycles the receiver holds off during the pressure phase.
  localparam int HOLD_CYCLES  = 300;
  // Items per random phase; four phases plus the pressure text and the
  // directed part come to a bit over three hundred items.
  localparam int PHASE_ITEMS  = 62;
  localparam int PRESSURE_LEN = 40;
  // Cycles waited after the last expected byte has come out.
  localparam int TAIL_CYCLES  = 40;
  localparam int NUM_DIRECTED = 26;

  // Directed texts. Bit 8 marks the final byte of a text.
  // First text: every two-byte escape, the NUL hint and a raw DEL byte.
  // Second text: a stray continuation byte, a lead byte from F8 up, and
  // well-formed two-, three- and four-byte sequences.
  // Third text: a broken four-byte sequence followed by FF, which gives the
  // largest burst the block can produce from a single item.
  // Fourth text: a three-byte sequence cut short by the end of the text.
  localparam logic [8:0] DIRECTED_ITEMS [0:NUM_DIRECTED-1] = '{
    9'h008, 9'h00C, 9'h00A, 9'h00D, 9'h009, 9'h022, 9'h05C, 9'h000, 9'h17F,
    9'h080, 9'h0FF, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
    9'h0F0, 9'h09F, 9'h098, 9'h180,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1FF,
    9'h0E2, 9'h182
  };

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       s_tvalid_i = 1'b0;
  logic       s_tready_o;
  logic [7:0] s_tdata_i  = 8'h00;   // [7:0] in_byte
  logic       s_tlast_i  = 1'b0;    // in_final
  logic       m_tvalid_o;
  logic       m_tready_i = 1'b0;
  logic [7:0] m_tdata_o;            // [7:0] out_byte
  logic       m_tuser_o;            // [0] out_run_last
  logic       m_tlast_o;            // out_text_end

  int fail_count;
  int open_count;
  int checked_count;

  // Idle and stall chances in percent, set per phase by the stimulus.
  int send_idle  = 0;
  int recv_stall = 0;

  // The stimulus bumps hold_req to ask for a long hold-off; the receiver
  // process counts the hold down on its own.
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  int items_sent = 0;
  int texts_sent = 0;

  logic [7:0] text_q[$];

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  json_string_escaper_utf8 i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  jse_escape_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_tvalid_i),
    .s_tready_i      (s_tready_o),
    .s_tdata_i       (s_tdata_i),
    .s_tlast_i       (s_tlast_i),
    .m_tvalid_i      (m_tvalid_o),
    .m_tready_i      (m_tready_i),
    .m_tdata_i       (m_tdata_o),
    .m_tuser_i       (m_tuser_o),
    .m_tlast_i       (m_tlast_o),
    .fail_count_o    (fail_count),
    .open_count_o    (open_count),
    .checked_count_o (checked_count)
  );

  // Receiver: random stalls at the phase's rate, or a long hold-off when
  // one has been asked for. Ready changes only at rising edges.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  // Offer one input item and return at the edge where it is taken. Idle
  // cycles go before the item, so valid never drops between back-to-back
  // items and only one assignment to it happens per time step.
  task automatic send_item(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tlast_i  <= fin;
    do begin
      @(posedge clk_i);
    end while (!s_tready_o);
    items_sent++;
  endtask

  // Send the bytes gathered in text_q as one text, final flag on the last.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_item(text_q[i], i == text_q.size() - 1);
    end
    texts_sent++;
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Append one character of random kind to text_q. Most are well formed;
  // the rest are stray bytes, bad lead bytes, broken sequences and noise.
  // A broken sequence at the end of a text becomes a truncated one.
  task automatic add_random_char();
    int pick;
    int need;
    int conts;
    pick = $urandom_range(0, 99);
    if (pick < 26) begin
      text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 36) begin
      case ($urandom_range(0, 6))
        0: text_q.push_back(8'h08);
        1: text_q.push_back(8'h0C);
        2: text_q.push_back(8'h0A);
        3: text_q.push_back(8'h0D);
        4: text_q.push_back(8'h09);
        5: text_q.push_back(8'h22);
        default: text_q.push_back(8'h5C);
      endcase
    end else if (pick < 42) begin
      // Control bytes 01 to 1F pass through unless escaped, DEL too; NUL becomes a hint.
      case ($urandom_range(0, 2))
        0: text_q.push_back(8'h00);
        1: text_q.push_back(8'h7F);
        default: text_q.push_back(8'($urandom_range(1, 31)));
      endcase
    end else if (pick < 82) begin
      need = $urandom_range(2, 4);
      case (need)
        2: text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        3: text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: text_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      // Mostly complete sequences, sometimes cut short.
      if ($urandom_range(0, 99) < 80) begin
        conts = need - 1;
      end else begin
        conts = $urandom_range(0, need - 2);
      end
      for (int k = 0; k < conts; k++) begin
        text_q.push_back(rand_cont());
      end
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 0) begin
        text_q.push_back(rand_cont());
      end else begin
        text_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_text(input int len);
    text_q.delete();
    while (text_q.size() < len) begin
      add_random_char();
    end
    send_text();
  endtask

  // Stop offering items and wait until every expected byte has come out.
  // The count is read at the falling edge, after the checker has seen the
  // last accepted item; driving resumes at the next rising edge.
  task automatic drain();
    s_tvalid_i <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (open_count != 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int phase_start;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, without idling on either side.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(DIRECTED_ITEMS[i][7:0], DIRECTED_ITEMS[i][8]);
      if (DIRECTED_ITEMS[i][8]) begin
        texts_sent++;
      end
    end
    drain();

    // Random part in four idle patterns: none, sender idle, receiver
    // stalling, and both at once.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_random_text($urandom_range(1, 10));
      end
      drain();

      // After the first pattern, the receiver holds off for a long stretch
      // while the sender keeps offering a long text, so the block fills up
      // and has to stall its input.
      if (phase == 0) begin
        hold_req++;
        send_random_text(PRESSURE_LEN);
        drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d input items in %0d texts, %0d escaped bytes checked,",
             items_sent, texts_sent, checked_count);
    $display("under four idle patterns and one long output hold-off.");
    if (fail_count == 0 && open_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
